[hdl/lsrd_pkg.sv]
// Shared constants, types and a helper function for the level sensor reply deframer.
`timescale 1ns / 1ps

package lsrd_pkg;

   // Frame constants.
   localparam logic [7:0] REPLY_PREFIX       = 8'h3E;
   localparam logic [7:0] OPCODE_SINGLE_READ = 8'h06;
   localparam logic [7:0] CRC_POLY_REFL      = 8'h8C;
   localparam int         FRAME_LEN          = 9;
   localparam int         LINE_LEN           = FRAME_LEN - 1;
   localparam int         TAIL_START         = 3;
   localparam int         RESCAN_LEN         = FRAME_LEN - TAIL_START;
   localparam int         RESCAN_CNT_W       = $clog2(RESCAN_LEN + 1);
   localparam int         POS_W              = $clog2(FRAME_LEN + 1);

   typedef logic [POS_W-1:0]        frame_pos_type;
   typedef logic [RESCAN_CNT_W-1:0] rescan_cnt_type;

   // Named frame positions.
   localparam frame_pos_type POS_HUNT   = frame_pos_type'(0);
   localparam frame_pos_type POS_OPCODE = frame_pos_type'(2);
   localparam frame_pos_type POS_CHECK  = frame_pos_type'(FRAME_LEN - 1);

   // Bit steps left in the CRC unit after the first step, which runs on load.
   localparam logic [2:0] CRC_BITS_AFTER_LOAD = 3'd7;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_GOOD       = 2'd0,
      STATUS_BAD_OPCODE = 2'd1,
      STATUS_BAD_CRC    = 2'd2
   } status_type;

   // Commands to the bit-serial CRC unit.
   typedef struct packed {
      logic       clear;
      logic       load;
      logic [7:0] data;
   } crc_cmd_type;

   // Commands to the frame store.
   typedef struct packed {
      logic       shift;
      logic       rescan_load;
      logic       rescan_shift;
      logic [7:0] data;
   } store_cmd_type;

   // Fixed taps of the frame store.
   typedef struct packed {
      logic [7:0]  addr_early;
      logic [7:0]  addr;
      logic [7:0]  temp;
      logic [15:0] level;
      logic [15:0] freq;
      logic [7:0]  rescan_byte;
   } store_view_type;

   // One bit step of the reflected CRC-8 shift register.
   function automatic logic [7:0] crc_step(input logic [7:0] c);
      logic [7:0] shifted;
      shifted = {1'b0, c[7:1]};
      crc_step = c[0] ? (shifted ^ CRC_POLY_REFL) : shifted;
   endfunction

endpackage

[hdl/lsrd_crc.sv]
// Bit-serial CRC-8 unit: one bit of the running checksum per cycle.
`timescale 1ns / 1ps

module lsrd_crc
   import lsrd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  crc_cmd_type crc_cmd,
   output logic [7:0]  crc_value,
   output logic        crc_busy
);

   logic [7:0] crc_ff, crc_in;
   logic [2:0] bit_cnt_ff, bit_cnt_in;

   // Load folds in a word and takes its first bit; the remaining bits follow one per cycle.
   always_comb begin
      crc_in     = crc_ff;
      bit_cnt_in = bit_cnt_ff;
      if (crc_cmd.clear) begin
         crc_in     = '0;
         bit_cnt_in = '0;
      end else if (crc_cmd.load) begin
         crc_in     = crc_step(crc_ff ^ crc_cmd.data);
         bit_cnt_in = CRC_BITS_AFTER_LOAD;
      end else if (bit_cnt_ff != 3'd0) begin
         crc_in     = crc_step(crc_ff);
         bit_cnt_in = bit_cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff     <= '0;
         bit_cnt_ff <= '0;
      end else begin
         crc_ff     <= crc_in;
         bit_cnt_ff <= bit_cnt_in;
      end
   end

   assign crc_value = crc_ff;
   assign crc_busy  = (bit_cnt_ff != 3'd0);

endmodule

[hdl/lsrd_store.sv]
// Frame store: a shift line of received frame words and a rescan line for the tail.
`timescale 1ns / 1ps

module lsrd_store
   import lsrd_pkg::*;
(
   input  logic           clock,
   input  store_cmd_type  store_cmd,
   output store_view_type store_view
);

   logic [7:0] line_ff   [0:LINE_LEN-1];
   logic [7:0] rescan_ff [0:RESCAN_LEN-1];

   // Every fed word enters at the top of the line; after eight words entry k holds frame word k.
   always_ff @(posedge clock) begin
      if (store_cmd.shift) begin
         for (int k = 0; k < LINE_LEN - 1; k++) begin
            line_ff[k] <= line_ff[k+1];
         end
         line_ff[LINE_LEN-1] <= store_cmd.data;
      end
   end

   // The tail of a failed frame is copied out and replayed one word at a time.
   always_ff @(posedge clock) begin
      if (store_cmd.rescan_load) begin
         for (int k = 0; k < RESCAN_LEN - 1; k++) begin
            rescan_ff[k] <= line_ff[TAIL_START+k];
         end
         rescan_ff[RESCAN_LEN-1] <= store_cmd.data;
      end else if (store_cmd.rescan_shift) begin
         for (int k = 0; k < RESCAN_LEN - 1; k++) begin
            rescan_ff[k] <= rescan_ff[k+1];
         end
      end
   end

   // Fixed taps: the address right after it arrives, and the fields of a full frame.
   assign store_view.addr_early  = line_ff[LINE_LEN-1];
   assign store_view.addr        = line_ff[1];
   assign store_view.temp        = line_ff[3];
   assign store_view.level       = {line_ff[5], line_ff[4]};
   assign store_view.freq        = {line_ff[7], line_ff[6]};
   assign store_view.rescan_byte = rescan_ff[0];

endmodule

[hdl/level_sensor_reply_deframer_top.sv]
// Top level of the level sensor reply deframer: frame control, result holding and output.
//
//   Channel  Ports                        Direction  Contents of one word
//   req      req_valid/req_stall          in         req_rx_byte
//   rsp      rsp_valid/rsp_stall          out        status, address, temperature, level,
//                                                    frequency, last_of_run
//
// A word that enters the checksum holds off input while the bit-serial CRC unit shifts it (one bit
// per cycle); a dropped hunt word, an opcode error or the check word does not start the CRC unit.
// A checksum mismatch replays six tail words through the same path;
// its results leave as the replay finds them, and the last one once the replay has ended.
// Reset is synchronous and active high; it returns the deframer to hunting with a clear CRC.
// Input is stalled while the CRC unit works, during a replay, or while results wait to go out.
`timescale 1ns / 1ps

module level_sensor_reply_deframer_top
   import lsrd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_sensor_address,
   output logic signed [7:0]  rsp_temperature,
   output logic [15:0]        rsp_fuel_level,
   output logic [15:0]        rsp_frequency,
   output logic               rsp_last_of_run
);

   frame_pos_type  pos_ff, pos_in;
   rescan_cnt_type rescan_left_ff, rescan_left_in;
   logic           pend_valid_ff, pend_valid_in;
   status_type     pend_status_ff, pend_status_in;
   logic [7:0]     pend_addr_ff, pend_addr_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [7:0]        rsp_addr_ff, rsp_addr_in;
   logic signed [7:0] rsp_temp_ff, rsp_temp_in;
   logic [15:0]       rsp_level_ff, rsp_level_in;
   logic [15:0]       rsp_freq_ff, rsp_freq_in;
   logic              rsp_last_ff, rsp_last_in;

   crc_cmd_type    crc_cmd;
   logic [7:0]     crc_value;
   logic           crc_busy;
   store_cmd_type  store_cmd;
   store_view_type store_view;

   logic              out_free, req_take, rescan_go, feed_go, flush_go, tail_load;
   logic [7:0]        feed_byte;
   logic              res_go;
   status_type        res_status;
   logic [7:0]        res_addr;
   logic signed [7:0] res_temp;
   logic [15:0]       res_level;
   logic [15:0]       res_freq;

   lsrd_crc u_crc (
      .clock     (clock),
      .reset     (reset),
      .crc_cmd   (crc_cmd),
      .crc_value (crc_value),
      .crc_busy  (crc_busy)
   );

   lsrd_store u_store (
      .clock      (clock),
      .store_cmd  (store_cmd),
      .store_view (store_view)
   );

   // Handshake and feed source selection; replay words take priority over new input.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = crc_busy || (rescan_left_ff != '0) || pend_valid_ff || !out_free;
   assign req_take  = req_valid && !req_stall;
   assign rescan_go = (rescan_left_ff != '0) && !crc_busy && out_free;
   assign feed_go   = req_take || rescan_go;
   assign feed_byte = rescan_go ? store_view.rescan_byte : req_rx_byte;
   assign flush_go  = (rescan_left_ff == '0) && pend_valid_ff && out_free;

   assign store_cmd.shift        = feed_go;
   assign store_cmd.rescan_load  = tail_load;
   assign store_cmd.rescan_shift = rescan_go;
   assign store_cmd.data         = feed_byte;

   // Frame decode for one fed word.
   always_comb begin
      pos_in        = pos_ff;
      crc_cmd.clear = 1'b0;
      crc_cmd.load  = 1'b0;
      crc_cmd.data  = feed_byte;
      tail_load     = 1'b0;
      res_go        = 1'b0;
      res_status    = STATUS_GOOD;
      res_addr      = '0;
      res_temp      = '0;
      res_level     = '0;
      res_freq      = '0;
      if (feed_go) begin
         if (pos_ff == POS_HUNT) begin
            if (feed_byte == REPLY_PREFIX) begin
               pos_in       = pos_ff + frame_pos_type'(1);
               crc_cmd.load = 1'b1;
            end
         end else if (pos_ff == POS_OPCODE && feed_byte != OPCODE_SINGLE_READ) begin
            res_go        = 1'b1;
            res_status    = STATUS_BAD_OPCODE;
            res_addr      = store_view.addr_early;
            pos_in        = POS_HUNT;
            crc_cmd.clear = 1'b1;
         end else if (pos_ff == POS_CHECK) begin
            res_go        = 1'b1;
            res_addr      = store_view.addr;
            pos_in        = POS_HUNT;
            crc_cmd.clear = 1'b1;
            if (crc_value == feed_byte) begin
               res_status = STATUS_GOOD;
               res_temp   = $signed(store_view.temp);
               res_level  = store_view.level;
               res_freq   = store_view.freq;
            end else begin
               res_status = STATUS_BAD_CRC;
               tail_load  = 1'b1;
            end
         end else if (pos_ff > POS_CHECK) begin
            pos_in        = POS_HUNT;
            crc_cmd.clear = 1'b1;
         end else begin
            pos_in       = pos_ff + frame_pos_type'(1);
            crc_cmd.load = 1'b1;
         end
      end
   end

   // Result routing: a mismatch or replay result is held until it is known if it ends the run.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_temp_in    = rsp_temp_ff;
      rsp_level_in   = rsp_level_ff;
      rsp_freq_in    = rsp_freq_ff;
      rsp_last_in    = rsp_last_ff;
      pend_valid_in  = pend_valid_ff;
      pend_status_in = pend_status_ff;
      pend_addr_in   = pend_addr_ff;
      rescan_left_in = rescan_left_ff;
      if (tail_load) begin
         rescan_left_in = rescan_cnt_type'(RESCAN_LEN);
      end else if (rescan_go) begin
         rescan_left_in = rescan_left_ff - rescan_cnt_type'(1);
      end
      if (flush_go) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = pend_status_ff;
         rsp_addr_in   = pend_addr_ff;
         rsp_temp_in   = '0;
         rsp_level_in  = '0;
         rsp_freq_in   = '0;
         rsp_last_in   = 1'b1;
         pend_valid_in = 1'b0;
      end else if (res_go) begin
         if (rescan_go) begin
            rsp_valid_in   = 1'b1;
            rsp_status_in  = pend_status_ff;
            rsp_addr_in    = pend_addr_ff;
            rsp_temp_in    = '0;
            rsp_level_in   = '0;
            rsp_freq_in    = '0;
            rsp_last_in    = 1'b0;
            pend_valid_in  = 1'b1;
            pend_status_in = res_status;
            pend_addr_in   = res_addr;
         end else if (res_status == STATUS_BAD_CRC) begin
            pend_valid_in  = 1'b1;
            pend_status_in = res_status;
            pend_addr_in   = res_addr;
         end else begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = res_status;
            rsp_addr_in   = res_addr;
            rsp_temp_in   = res_temp;
            rsp_level_in  = res_level;
            rsp_freq_in   = res_freq;
            rsp_last_in   = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= POS_HUNT;
         rescan_left_ff <= '0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         pos_ff         <= pos_in;
         rescan_left_ff <= rescan_left_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pend_status_ff <= pend_status_in;
      pend_addr_ff   <= pend_addr_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_addr_ff    <= rsp_addr_in;
      rsp_temp_ff    <= rsp_temp_in;
      rsp_level_ff   <= rsp_level_in;
      rsp_freq_ff    <= rsp_freq_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_sensor_address = rsp_addr_ff;
   assign rsp_temperature    = rsp_temp_ff;
   assign rsp_fuel_level     = rsp_level_ff;
   assign rsp_frequency      = rsp_freq_ff;
   assign rsp_last_of_run    = rsp_last_ff;

   // A replay always runs behind a held result.
   a_rescan_has_pending: assert property (@(posedge clock) disable iff (reset)
      (rescan_left_ff != '0) |-> pend_valid_ff)
      else $error("replay running without a held result");

   // A word that is not the last of its run is always followed by a held result.
   a_not_last_has_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> pend_valid_ff)
      else $error("run left open with nothing held");

   // No word is fed while the CRC unit is still shifting.
   a_no_feed_while_crc: assert property (@(posedge clock) disable iff (reset)
      crc_busy |-> !feed_go)
      else $error("word fed while CRC busy");

   // The frame position never runs past the check word.
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_CHECK)
      else $error("frame position out of range");

endmodule
